>>> design/mels_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mels_pkg
// shared constants, codes and controller/datapath types of the max store
// ----------------------------------------------------------------------------
package mels_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_INPUT,
        RES_BEST
    } t_res_src;

    typedef struct packed {
        logic                capture;
        logic                ins_write;
        logic                rd_issue;
        logic                move_rd;
        logic                move_wr;
        logic                set_res;
        logic [STATUS_W-1:0] res_status;
        t_res_src            res_src;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            scan_issued;
        logic            chk_pending;
        logic            found;
        logic            out_free;
    } t_dp_sts;

endpackage

>>> design/mels_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mels_if
// request and response channels of the max store
// ----------------------------------------------------------------------------
interface mels_req_if;
    logic                                valid;
    logic                                ready;
    logic [mels_pkg::OP_W-1:0]           op;
    logic signed [mels_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface mels_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [mels_pkg::STATUS_W-1:0]       status;
    logic signed [mels_pkg::VALUE_W-1:0] result_value;
    logic [mels_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output result_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input result_value,
                    input entry_count, output ready);
endinterface

>>> design/mels_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mels_ctrl
// sequencer: decode, scan, compaction move and result hand-off
// ----------------------------------------------------------------------------
module mels_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  mels_pkg::t_dp_sts i_sts,
    output logic              o_req_ready,
    output mels_pkg::t_dp_cmd o_cmd
);

    mels_pkg::t_state r_state;
    mels_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mels_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            mels_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mels_pkg::ST_DECODE;
                end
            end
            mels_pkg::ST_DECODE: begin
                o_cmd.set_res = 1'b1;
                n_state       = mels_pkg::ST_DONE;
                case (i_sts.op)
                    mels_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.res_status = mels_pkg::STAT_FULL;
                            o_cmd.res_src    = mels_pkg::RES_ZERO;
                        end else begin
                            o_cmd.ins_write  = 1'b1;
                            o_cmd.res_status = mels_pkg::STAT_OK;
                            o_cmd.res_src    = mels_pkg::RES_INPUT;
                        end
                    end
                    mels_pkg::OP_EXTRACT: begin
                        if (i_sts.empty) begin
                            o_cmd.res_status = mels_pkg::STAT_EMPTY;
                            o_cmd.res_src    = mels_pkg::RES_ZERO;
                        end else begin
                            o_cmd.set_res = 1'b0;
                            n_state       = mels_pkg::ST_SCAN;
                        end
                    end
                    mels_pkg::OP_ERASE: begin
                        o_cmd.set_res = 1'b0;
                        n_state       = mels_pkg::ST_SCAN;
                    end
                    default: begin
                        o_cmd.res_status = mels_pkg::STAT_OK;
                        o_cmd.res_src    = mels_pkg::RES_ZERO;
                    end
                endcase
            end
            mels_pkg::ST_SCAN: begin
                if (!i_sts.scan_issued) begin
                    o_cmd.rd_issue = 1'b1;
                end else if (!i_sts.chk_pending) begin
                    if (i_sts.found) begin
                        n_state = mels_pkg::ST_MOVE_RD;
                    end else begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = mels_pkg::STAT_NOT_FOUND;
                        o_cmd.res_src    = mels_pkg::RES_ZERO;
                        n_state          = mels_pkg::ST_DONE;
                    end
                end
            end
            mels_pkg::ST_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = mels_pkg::ST_MOVE_WR;
            end
            mels_pkg::ST_MOVE_WR: begin
                o_cmd.move_wr    = 1'b1;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = mels_pkg::STAT_OK;
                o_cmd.res_src    = mels_pkg::RES_BEST;
                n_state          = mels_pkg::ST_DONE;
            end
            mels_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mels_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mels_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/mels_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mels_dp
// packed value memory, scan compare, entry count and output register
// ----------------------------------------------------------------------------
module mels_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mels_pkg::t_dp_cmd                   i_cmd,
    input  logic [mels_pkg::OP_W-1:0]           i_op,
    input  logic signed [mels_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_out_ready,
    output mels_pkg::t_dp_sts                   o_sts,
    output logic                                o_out_valid,
    output logic [mels_pkg::STATUS_W-1:0]       o_status,
    output logic signed [mels_pkg::VALUE_W-1:0] o_result_value,
    output logic [mels_pkg::COUNT_W-1:0]        o_entry_count
);

    // values stay packed in slots 0 .. count-1
    logic signed [mels_pkg::VALUE_W-1:0] r_mem [mels_pkg::MAX_ENTRIES];
    logic signed [mels_pkg::VALUE_W-1:0] r_rd_data;

    logic [mels_pkg::OP_W-1:0]           r_op;
    logic signed [mels_pkg::VALUE_W-1:0] r_value;
    logic [mels_pkg::CNT_W-1:0]          r_count;
    logic [mels_pkg::CNT_W-1:0]          r_rd_idx;
    logic                                r_chk_vld;
    logic [mels_pkg::IDX_W-1:0]          r_chk_idx;
    logic                                r_found;
    logic signed [mels_pkg::VALUE_W-1:0] r_best;
    logic [mels_pkg::IDX_W-1:0]          r_best_idx;
    logic [mels_pkg::STATUS_W-1:0]       r_res_status;
    logic signed [mels_pkg::VALUE_W-1:0] r_res_value;
    logic                                r_out_valid;
    logic [mels_pkg::STATUS_W-1:0]       r_out_status;
    logic signed [mels_pkg::VALUE_W-1:0] r_out_value;
    logic [mels_pkg::COUNT_W-1:0]        r_out_count;

    logic [mels_pkg::CNT_W-1:0] w_last;
    logic [mels_pkg::IDX_W-1:0] w_rd_addr;
    logic                       w_rd_en;
    logic [mels_pkg::IDX_W-1:0] w_wr_addr;
    logic signed [mels_pkg::VALUE_W-1:0] w_wr_data;
    logic                       w_wr_en;
    logic                       w_hit;
    logic                       w_full;

    assign w_last    = r_count - mels_pkg::CNT_W'(1);
    assign w_rd_en   = i_cmd.rd_issue | i_cmd.move_rd;
    assign w_rd_addr = i_cmd.move_rd ? w_last[mels_pkg::IDX_W-1:0]
                                     : r_rd_idx[mels_pkg::IDX_W-1:0];
    assign w_wr_en   = i_cmd.ins_write | i_cmd.move_wr;
    assign w_wr_addr = i_cmd.move_wr ? r_best_idx : r_count[mels_pkg::IDX_W-1:0];
    assign w_wr_data = i_cmd.move_wr ? r_rd_data : r_value;
    assign w_full    = (r_count == mels_pkg::CNT_W'(mels_pkg::MAX_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // extract keeps the first greatest, erase the first equal
    always_comb begin
        if (r_op == mels_pkg::OP_EXTRACT) begin
            w_hit = !r_found || (r_best < r_rd_data);
        end else begin
            w_hit = !r_found && (r_rd_data == r_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_idx  <= '0;
                r_chk_vld <= 1'b0;
                r_found   <= 1'b0;
            end else begin
                r_chk_vld <= i_cmd.rd_issue;
                if (i_cmd.rd_issue) begin
                    r_rd_idx <= r_rd_idx + mels_pkg::CNT_W'(1);
                end
                if (r_chk_vld && w_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.ins_write) begin
                r_count <= r_count + mels_pkg::CNT_W'(1);
            end else if (i_cmd.move_wr) begin
                r_count <= w_last;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (i_cmd.rd_issue) begin
            r_chk_idx <= r_rd_idx[mels_pkg::IDX_W-1:0];
        end
        if (r_chk_vld && w_hit) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_chk_idx;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_src)
                mels_pkg::RES_INPUT: r_res_value <= r_value;
                mels_pkg::RES_BEST:  r_res_value <= r_best;
                default:             r_res_value <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_count  <= mels_pkg::COUNT_W'(r_count);
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.full        = w_full;
    assign o_sts.empty       = (r_count == '0);
    assign o_sts.scan_issued = (r_rd_idx == r_count);
    assign o_sts.chk_pending = r_chk_vld;
    assign o_sts.found       = r_found;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_value;
    assign o_entry_count  = r_out_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mels_pkg::CNT_W'(mels_pkg::MAX_ENTRIES))
        else $error("entry count above capacity");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |-> !w_full)
        else $error("insert written into a full store");

    a_move_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move_wr |-> (r_found && (r_count != '0)))
        else $error("compaction move without a located entry");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_rd_idx < r_count))
        else $error("scan read beyond stored entries");
`endif

endmodule

>>> design/max_extract_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_extract_list_store_core
// bounded store of signed values with insert, extract-max and erase
// ----------------------------------------------------------------------------
// usage
//   i_req carries one operation per transfer (op, value); o_rsp returns one
//   result per operation (status, result_value, entry_count)
//   op insert: value goes into the next free slot, status full if no room
//   op extract: greatest stored value is removed and returned
//   op erase: one copy of value is removed, status not found if absent
// sequencing
//   one operation at a time; i_req.ready is high only while idle, from the
//   edge o_rsp.valid rises, so each transfer waits for the previous result
//   insert, extract on empty and the unused op skip the scan and the move
//   extract and erase: the linear scan reads one slot per cycle through the
//   single read port, then the last entry moves into the freed slot; an
//   erase that misses skips the move
// reset
//   synchronous active-low reset empties the store at once (count cleared)
// stall
//   a result waits in the output register while o_rsp.ready is low; the next
//   request is already taken and held in the done state until the register
//   frees up
// ----------------------------------------------------------------------------
module max_extract_list_store_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mels_req_if.sink   i_req,
    mels_rsp_if.source o_rsp
);

    mels_pkg::t_dp_cmd w_cmd;
    mels_pkg::t_dp_sts w_sts;
    logic              w_req_ready;

    // sequencer owns the flow, datapath owns every stored value
    mels_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    mels_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_req.op),
        .i_value        (i_req.value),
        .i_out_ready    (o_rsp.ready),
        .o_sts          (w_sts),
        .o_out_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_result_value (o_rsp.result_value),
        .o_entry_count  (o_rsp.entry_count)
    );

    assign i_req.ready = w_req_ready;

endmodule

>>> tb/mels_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mels_store_checker
// watches the request and result channels of the max store, keeps its own
// copy of the stored values, predicts every result and compares it
// ----------------------------------------------------------------------------
module mels_store_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mels_req_if  i_req,
    mels_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_hits,
    output int   o_empty_hits,
    output int   o_miss_hits,
    output int   o_peak_count
);

    typedef struct packed {
        logic [mels_pkg::STATUS_W-1:0]       status;
        logic signed [mels_pkg::VALUE_W-1:0] result_value;
        logic [mels_pkg::COUNT_W-1:0]        entry_count;
    } t_store_result;

    // stored values as a multiset: equal copies cannot be told apart
    logic signed [mels_pkg::VALUE_W-1:0] held_values[$];
    t_store_result                       pending_results[$];
    t_store_result                       want;

    function automatic t_store_result apply_op(
        input logic [mels_pkg::OP_W-1:0]           op,
        input logic signed [mels_pkg::VALUE_W-1:0] val
    );
        t_store_result r;
        int            pos;
        r.status       = mels_pkg::STAT_OK;
        r.result_value = '0;
        pos            = -1;
        case (op)
            mels_pkg::OP_INSERT: begin
                if (held_values.size() < mels_pkg::MAX_ENTRIES) begin
                    held_values.push_back(val);
                    r.result_value = val;
                end else begin
                    r.status = mels_pkg::STAT_FULL;
                end
            end
            mels_pkg::OP_EXTRACT: begin
                foreach (held_values[i])
                    if (pos < 0 || held_values[i] > held_values[pos]) pos = i;
                if (pos < 0) begin
                    r.status = mels_pkg::STAT_EMPTY;
                end else begin
                    r.result_value = held_values[pos];
                    held_values.delete(pos);
                end
            end
            mels_pkg::OP_ERASE: begin
                foreach (held_values[i])
                    if (pos < 0 && held_values[i] == val) pos = i;
                if (pos < 0) begin
                    r.status = mels_pkg::STAT_NOT_FOUND;
                end else begin
                    r.result_value = val;
                    held_values.delete(pos);
                end
            end
            default: ;
        endcase
        r.entry_count = mels_pkg::COUNT_W'(held_values.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_values.delete();
            pending_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_full_hits  = 0;
            o_empty_hits = 0;
            o_miss_hits  = 0;
            o_peak_count = 0;
        end else begin
            // results first: one landing on this edge belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d value %0d count %0d",
                           i_rsp.status, i_rsp.result_value, i_rsp.entry_count);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    o_checked++;
                    if (i_rsp.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (i_rsp.result_value !== want.result_value) begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want.result_value, i_rsp.result_value);
                        o_fail_count++;
                    end
                    if (i_rsp.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, i_rsp.entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = apply_op(i_req.op, i_req.value);
                pending_results.push_back(want);
                case (want.status)
                    mels_pkg::STAT_FULL:      o_full_hits++;
                    mels_pkg::STAT_EMPTY:     o_empty_hits++;
                    mels_pkg::STAT_NOT_FOUND: o_miss_hits++;
                    default: ;
                endcase
                if (held_values.size() > o_peak_count) o_peak_count = held_values.size();
            end
        end
        o_pending = pending_results.size();
    end

endmodule

>>> tb/tb_max_extract_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_extract_list_store_core
// drives insert, extract-max and erase operations into the max store, with
// random gaps on the request side and random stalls on the result side;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_max_extract_list_store_core;

    // selector value with no operation behind it
    localparam logic [mels_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_OPS   = 1700;
    localparam int PHASE_LEN    = 150;   // ops per fill / mixed / drain phase
    localparam int STEADY_FIRST = 700;   // window with no idling on either side
    localparam int STEADY_LAST  = 1000;
    localparam int DRAIN_CYCLES = 80;    // the longest scan covers every stored entry

    logic i_clk;
    logic i_rst_n;
    logic steady;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int miss_hits;
    int peak_count;

    // values sent with inserts, so that erases mostly hit something stored
    logic signed [mels_pkg::VALUE_W-1:0] recent_values[$];

    mels_req_if req_ch ();
    mels_rsp_if rsp_ch ();

    max_extract_list_store_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mels_store_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_hits  (full_hits),
        .o_empty_hits (empty_hits),
        .o_miss_hits  (miss_hits),
        .o_peak_count (peak_count)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // result side: stall at random, except inside the steady window
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (steady) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 36);
        end
    end

    // one operation per call; entered and left at a falling edge.
    // valid is only lowered inside the gap loop, so back-to-back transfers
    // never see a low and a high assignment in the same step
    task automatic send_op(input logic [mels_pkg::OP_W-1:0] op,
                           input logic signed [mels_pkg::VALUE_W-1:0] val);
        while (!steady && $urandom_range(99) < 36) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == mels_pkg::OP_INSERT) begin
            recent_values.push_back(val);
            if (recent_values.size() > mels_pkg::MAX_ENTRIES)
                void'(recent_values.pop_front());
        end
    endtask

    // mix of full-range values, a narrow band that makes duplicates, the
    // extremes, and values already inserted
    function automatic logic signed [mels_pkg::VALUE_W-1:0] pick_value(input int reuse_pct);
        int roll;
        int sel;
        roll = $urandom_range(99);
        if (recent_values.size() > 0 && roll < reuse_pct)
            return recent_values[$urandom_range(recent_values.size() - 1)];
        roll = $urandom_range(99);
        if (roll < 45) return mels_pkg::VALUE_W'($urandom);
        if (roll < 75) return mels_pkg::VALUE_W'($signed($urandom_range(8)) - 4);
        sel = $urandom_range(3);
        case (sel)
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // phase 0 fills the store to overflow, phase 2 drains it past empty
    function automatic logic [mels_pkg::OP_W-1:0] pick_op(input int phase);
        int roll;
        int ins_pct;
        int ext_pct;
        roll    = $urandom_range(99);
        ins_pct = (phase == 0) ? 85 : (phase == 2) ? 10 : 46;
        ext_pct = (phase == 2) ? 45 : 25;
        if (roll < ins_pct)               return mels_pkg::OP_INSERT;
        if (roll < ins_pct + ext_pct)     return mels_pkg::OP_EXTRACT;
        if (roll < 96)                    return mels_pkg::OP_ERASE;
        return OP_UNUSED;
    endfunction

    initial begin : stimulus
        logic [mels_pkg::OP_W-1:0] op;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        steady       = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = mels_pkg::OP_INSERT;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-store errors, the unused selector, extremes,
        // duplicates of the maximum and of erase targets
        send_op(mels_pkg::OP_EXTRACT, 16'sh1234);
        send_op(mels_pkg::OP_ERASE,   16'sh0000);
        send_op(OP_UNUSED,            16'sh0000);
        send_op(mels_pkg::OP_INSERT,  16'sh7fff);
        send_op(mels_pkg::OP_INSERT,  16'sh8000);
        send_op(mels_pkg::OP_INSERT,  16'sh0000);
        send_op(mels_pkg::OP_INSERT,  16'shffff);
        send_op(mels_pkg::OP_INSERT,  16'sh0001);
        send_op(mels_pkg::OP_INSERT,  16'sh5555);
        send_op(mels_pkg::OP_INSERT,  16'shaaaa);
        send_op(mels_pkg::OP_INSERT,  16'sh7fff);
        send_op(mels_pkg::OP_ERASE,   16'sh3039);
        send_op(OP_UNUSED,            16'shffff);
        send_op(mels_pkg::OP_EXTRACT, 16'sh0000);
        send_op(mels_pkg::OP_EXTRACT, 16'shffff);
        send_op(mels_pkg::OP_EXTRACT, 16'sh0000);
        send_op(mels_pkg::OP_INSERT,  16'shffff);
        send_op(mels_pkg::OP_ERASE,   16'shffff);
        send_op(mels_pkg::OP_ERASE,   16'sh8000);
        send_op(mels_pkg::OP_ERASE,   16'sh8000);
        send_op(mels_pkg::OP_ERASE,   16'shaaaa);
        send_op(mels_pkg::OP_EXTRACT, 16'sh0000);
        send_op(OP_UNUSED,            16'sh5555);

        // random: fill, mixed, drain, mixed phases in turn
        for (int k = 0; k < RANDOM_OPS; k++) begin
            steady = (k >= STEADY_FIRST && k < STEADY_LAST);
            op     = pick_op((k / PHASE_LEN) % 4);
            send_op(op, pick_value((op == mels_pkg::OP_ERASE) ? 65 : 15));
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        // let every outstanding result come home, then DRAIN_CYCLES more
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d results checked, store depth peaked at %0d of %0d",
                 checked, peak_count, mels_pkg::MAX_ENTRIES);
        $display("run: %0d inserts refused as full, %0d extracts on empty, %0d erase misses",
                 full_hits, empty_hits, miss_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, well above the slowest expected run
    initial begin
        #6_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
